FILE: hdl/tsds_pkg.sv
// Shared constants, codes and helpers for the tracker station deadband store.
package tsds_pkg;

	// Default station count
	localparam int NUM_STATIONS_DEF = 12;

	// Field widths
	localparam int MASK_W    = 12;
	localparam int STATION_W = 4;
	localparam int POS_W     = 20;
	localparam int QUAT_W    = 16;
	localparam int TIME_W    = 32;
	localparam int PTH_W     = 42;
	localparam int QTH_W     = 34;
	localparam int CFG_W     = 42;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W  = 3;

	// Shared difference-square unit widths
	localparam int DIFF_W = POS_W + 1;
	localparam int ABS_W  = POS_W;
	localparam int PROD_W = 2 * ABS_W;

	// Operations
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FETCH  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DISCARDED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FETCHED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_THR     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_THR    = 2'd2;

	// Register reset values
	localparam logic [MASK_W-1:0] ACTIVE_MASK_RST = 12'd1;

	// Address width for a store of the given depth, at least one bit
	function automatic int addr_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

FILE: hdl/tsds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tsds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [tsds_pkg::addr_width(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [tsds_pkg::addr_width(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/tracker_station_deadband_store.sv
// Top level of the tracker station deadband store: sequencer, shared unit and stores.
// A sample reads its record through the shared unit and writes back if stored; a bad station
// skips to the result. A fetch scans one station a cycle from the serve pointer, then
// reads the record. One item at a time: no new input before the result reaches the output.
// Samples pay for seven passes through the shared square unit and, if stored, a store write-back.
// Reset clears flags, pointer, registers and handshakes; store contents stay unknown.
module tracker_station_deadband_store #(
	parameter int NUM_STATIONS = tsds_pkg::NUM_STATIONS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 operation,
	input  logic [tsds_pkg::STATION_W-1:0]       station,
	input  logic signed [tsds_pkg::POS_W-1:0]    pos_x,
	input  logic signed [tsds_pkg::POS_W-1:0]    pos_y,
	input  logic signed [tsds_pkg::POS_W-1:0]    pos_z,
	input  logic signed [tsds_pkg::QUAT_W-1:0]   quat_w,
	input  logic signed [tsds_pkg::QUAT_W-1:0]   quat_x,
	input  logic signed [tsds_pkg::QUAT_W-1:0]   quat_y,
	input  logic signed [tsds_pkg::QUAT_W-1:0]   quat_z,
	input  logic [tsds_pkg::TIME_W-1:0]          sample_time,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [tsds_pkg::STATUS_W-1:0]        status,
	output logic [tsds_pkg::STATION_W-1:0]       out_station,
	output logic signed [tsds_pkg::POS_W-1:0]    out_pos_x,
	output logic signed [tsds_pkg::POS_W-1:0]    out_pos_y,
	output logic signed [tsds_pkg::POS_W-1:0]    out_pos_z,
	output logic signed [tsds_pkg::QUAT_W-1:0]   out_quat_w,
	output logic signed [tsds_pkg::QUAT_W-1:0]   out_quat_x,
	output logic signed [tsds_pkg::QUAT_W-1:0]   out_quat_y,
	output logic signed [tsds_pkg::QUAT_W-1:0]   out_quat_z,
	output logic [tsds_pkg::TIME_W-1:0]          out_time,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tsds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsds_pkg::CFG_W-1:0]           cfg_data
);

	localparam int KW        = tsds_pkg::addr_width(NUM_STATIONS);
	localparam int POS_DEPTH = 3 * NUM_STATIONS;
	localparam int ROT_DEPTH = 4 * NUM_STATIONS;
	localparam int PAW       = tsds_pkg::addr_width(POS_DEPTH);
	localparam int RAW       = tsds_pkg::addr_width(ROT_DEPTH);
	localparam int TAW       = tsds_pkg::addr_width(NUM_STATIONS);

	localparam int PW = tsds_pkg::POS_W;
	localparam int QW = tsds_pkg::QUAT_W;
	localparam int TW = tsds_pkg::TIME_W;
	localparam int SW = tsds_pkg::STATION_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CALC = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_SRCH = 3'd4;
	localparam logic [2:0] S_FRD  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	// Step counts within states
	localparam logic [3:0] CALC_ISSUE = 4'd7;
	localparam logic [3:0] CALC_LAST  = 4'd9;
	localparam logic [3:0] WR_LAST    = 4'd3;
	localparam logic [3:0] FRD_LAST   = 4'd4;
	localparam logic [3:0] N_POS      = 4'd3;
	localparam logic [3:0] N_QUAT     = 4'd4;

	logic [2:0]  state_q;
	logic [3:0]  cnt_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] n_q;
	logic [KW-1:0] serve_q;
	logic [NUM_STATIONS-1:0] seen_q;
	logic [NUM_STATIONS-1:0] pending_q;

	// Configuration registers
	logic [tsds_pkg::MASK_W-1:0] active_mask_q;
	logic [tsds_pkg::PTH_W-1:0]  pos_thr_q;
	logic [tsds_pkg::QTH_W-1:0]  quat_thr_q;

	// Captured input beat
	logic signed [PW-1:0] px_q, py_q, pz_q;
	logic signed [QW-1:0] qw_q, qx_q, qy_q, qz_q;
	logic [TW-1:0]        time_q;

	// Distance accumulators
	logic [tsds_pkg::PTH_W-1:0] pd_q;
	logic [tsds_pkg::QTH_W-1:0] qd_q;

	// Shared unit pipeline
	logic                         vld_s1, vld_s2, vld_s3;
	logic [2:0]                   comp_s1;
	logic                         isq_s2, isq_s3;
	logic [tsds_pkg::ABS_W-1:0]   diff_s2;
	logic [tsds_pkg::PROD_W-1:0]  prod_s3;

	// Staged result
	logic [tsds_pkg::STATUS_W-1:0] res_status_q;
	logic [SW-1:0]                 res_station_q;
	logic signed [PW-1:0]          res_px_q, res_py_q, res_pz_q;
	logic signed [QW-1:0]          res_qw_q, res_qx_q, res_qy_q, res_qz_q;
	logic [TW-1:0]                 res_time_q;

	// Output register
	logic out_valid_q;

	// Store ports
	logic          pos_we, pos_re, rot_we, rot_re, time_we, time_re;
	logic [PAW-1:0] pos_addr;
	logic [RAW-1:0] rot_addr;
	logic [TAW-1:0] time_addr;
	logic [PW-1:0]  pos_rdata;
	logic [QW-1:0]  rot_rdata;
	logic [TW-1:0]  time_rdata;

	logic [1:0] pos_idx, rot_idx, in_pos_idx, in_quat_idx;
	logic signed [PW-1:0] in_pos_sel;
	logic signed [QW-1:0] in_quat_sel;
	logic signed [tsds_pkg::DIFF_W-1:0] op_a, op_b, diff;
	logic [tsds_pkg::ABS_W-1:0] abs_diff;
	logic [15:0] mask_ext;
	logic        active, filt_pass, order_ok, do_store;
	logic        bad_station;
	logic [SW-1:0] station_m1;
	logic        accept_in, out_load;

	assign accept_in = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign station_m1  = station - SW'(1);
	assign bad_station = (station == '0) || ({1'b0, station} > 5'(NUM_STATIONS));

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mask_q <= tsds_pkg::ACTIVE_MASK_RST;
			pos_thr_q     <= '0;
			quat_thr_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsds_pkg::REG_ACTIVE_MASK: active_mask_q <= cfg_data[tsds_pkg::MASK_W-1:0];
				tsds_pkg::REG_POS_THR:     pos_thr_q     <= cfg_data[tsds_pkg::PTH_W-1:0];
				tsds_pkg::REG_QUAT_THR:    quat_thr_q    <= cfg_data[tsds_pkg::QTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Component indexes into the stores and the captured beat
	always_comb begin
		pos_idx = cnt_q[1:0];
		rot_idx = (state_q == S_CALC) ? 2'(cnt_q - N_POS) : cnt_q[1:0];
		if (state_q == S_WR) begin
			in_pos_idx  = cnt_q[1:0];
			in_quat_idx = cnt_q[1:0];
		end else begin
			in_pos_idx  = comp_s1[1:0];
			in_quat_idx = 2'(comp_s1 - 3'd3);
		end
	end

	always_comb begin
		case (in_pos_idx)
			2'd0:    in_pos_sel = px_q;
			2'd1:    in_pos_sel = py_q;
			default: in_pos_sel = pz_q;
		endcase
		case (in_quat_idx)
			2'd0:    in_quat_sel = qw_q;
			2'd1:    in_quat_sel = qx_q;
			2'd2:    in_quat_sel = qy_q;
			default: in_quat_sel = qz_q;
		endcase
	end

	// Store addressing and enables
	always_comb begin
		pos_addr  = PAW'(k_q) * PAW'(3) + PAW'(pos_idx);
		rot_addr  = RAW'({k_q, rot_idx});
		time_addr = TAW'(k_q);
		pos_re    = ((state_q == S_CALC) || (state_q == S_FRD)) && (cnt_q < N_POS);
		rot_re    = ((state_q == S_CALC) && (cnt_q >= N_POS) && (cnt_q < CALC_ISSUE)) ||
		            ((state_q == S_FRD) && (cnt_q < N_QUAT));
		time_re   = ((state_q == S_CALC) || (state_q == S_FRD)) && (cnt_q == '0);
		pos_we    = (state_q == S_WR) && (cnt_q < N_POS);
		rot_we    = (state_q == S_WR);
		time_we   = (state_q == S_WR) && (cnt_q == '0);
	end

	tsds_ram #(.WIDTH(PW), .DEPTH(POS_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_addr),
		.wdata (in_pos_sel),
		.re    (pos_re),
		.raddr (pos_addr),
		.rdata (pos_rdata)
	);

	tsds_ram #(.WIDTH(QW), .DEPTH(ROT_DEPTH)) u_rot_ram (
		.clk   (clk),
		.we    (rot_we),
		.waddr (rot_addr),
		.wdata (in_quat_sel),
		.re    (rot_re),
		.raddr (rot_addr),
		.rdata (rot_rdata)
	);

	tsds_ram #(.WIDTH(TW), .DEPTH(NUM_STATIONS)) u_time_ram (
		.clk   (clk),
		.we    (time_we),
		.waddr (time_addr),
		.wdata (time_q),
		.re    (time_re),
		.raddr (time_addr),
		.rdata (time_rdata)
	);

	// Shared unit: subtract and take magnitude
	always_comb begin
		if (comp_s1 < 3'd3) begin
			op_a = tsds_pkg::DIFF_W'(in_pos_sel);
			op_b = tsds_pkg::DIFF_W'($signed(pos_rdata));
		end else begin
			op_a = tsds_pkg::DIFF_W'(in_quat_sel);
			op_b = tsds_pkg::DIFF_W'($signed(rot_rdata));
		end
		diff     = op_a - op_b;
		abs_diff = diff[tsds_pkg::DIFF_W-1] ? tsds_pkg::ABS_W'(-diff)
		                                     : tsds_pkg::ABS_W'(diff);
	end

	// Shared unit pipeline: issue, magnitude, square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_CALC) && (cnt_q < CALC_ISSUE);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		comp_s1 <= cnt_q[2:0];
		diff_s2 <= abs_diff;
		isq_s2  <= (comp_s1 >= 3'd3);
		prod_s3 <= tsds_pkg::PROD_W'(diff_s2) * tsds_pkg::PROD_W'(diff_s2);
		isq_s3  <= isq_s2;
	end

	// Filter decision
	always_comb begin
		mask_ext  = 16'(active_mask_q);
		active    = mask_ext[4'(k_q)];
		filt_pass = !seen_q[k_q] || ((pos_thr_q == '0) && (quat_thr_q == '0)) ||
		            (pos_thr_q <= pd_q) || (quat_thr_q <= qd_q);
		order_ok  = !seen_q[k_q] || (time_q >= time_rdata);
		do_store  = active && filt_pass && order_ok;
	end

	// Sequencer and flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			k_q       <= '0;
			n_q       <= '0;
			serve_q   <= '0;
			seen_q    <= '0;
			pending_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						cnt_q <= '0;
						n_q   <= '0;
						if (operation == tsds_pkg::OP_FETCH) begin
							k_q     <= serve_q;
							state_q <= S_SRCH;
						end else if (bad_station) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= station_m1[KW-1:0];
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == CALC_LAST) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					cnt_q   <= '0;
					state_q <= do_store ? S_WR : S_DONE;
				end
				S_WR: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == WR_LAST) begin
						seen_q[k_q]    <= 1'b1;
						pending_q[k_q] <= 1'b1;
						state_q        <= S_DONE;
					end
				end
				S_SRCH: begin
					if (pending_q[k_q]) begin
						cnt_q   <= '0;
						state_q <= S_FRD;
					end else if (n_q == KW'(NUM_STATIONS - 1)) begin
						state_q <= S_DONE;
					end else begin
						k_q <= (k_q == KW'(NUM_STATIONS - 1)) ? '0 : k_q + KW'(1);
						n_q <= n_q + KW'(1);
					end
				end
				S_FRD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == FRD_LAST) begin
						serve_q        <= k_q;
						pending_q[k_q] <= 1'b0;
						state_q        <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the beat, accumulate distances, build the result
	always_ff @(posedge clk) begin
		if (accept_in) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
			qw_q   <= quat_w;
			qx_q   <= quat_x;
			qy_q   <= quat_y;
			qz_q   <= quat_z;
			time_q <= sample_time;
			pd_q   <= '0;
			qd_q   <= '0;
			res_station_q <= '0;
			res_px_q      <= '0;
			res_py_q      <= '0;
			res_pz_q      <= '0;
			res_qw_q      <= '0;
			res_qx_q      <= '0;
			res_qy_q      <= '0;
			res_qz_q      <= '0;
			res_time_q    <= '0;
			if (operation == tsds_pkg::OP_SAMPLE && bad_station) begin
				res_status_q <= tsds_pkg::ST_BAD;
			end
		end
		if (vld_s3) begin
			if (isq_s3) begin
				qd_q <= qd_q + tsds_pkg::QTH_W'(prod_s3);
			end else begin
				pd_q <= pd_q + tsds_pkg::PTH_W'(prod_s3);
			end
		end
		if (state_q == S_DEC) begin
			res_status_q <= do_store ? tsds_pkg::ST_STORED : tsds_pkg::ST_DISCARDED;
		end
		if (state_q == S_SRCH && !pending_q[k_q]) begin
			res_status_q <= tsds_pkg::ST_NONE;
		end
		// gather the record from the registered read data of each store read
		if (state_q == S_FRD) begin
			res_status_q  <= tsds_pkg::ST_FETCHED;
			res_station_q <= SW'(k_q) + SW'(1);
			case (cnt_q)
				4'd1: begin
					res_px_q   <= $signed(pos_rdata);
					res_qw_q   <= $signed(rot_rdata);
					res_time_q <= time_rdata;
				end
				4'd2: begin
					res_py_q <= $signed(pos_rdata);
					res_qx_q <= $signed(rot_rdata);
				end
				4'd3: begin
					res_pz_q <= $signed(pos_rdata);
					res_qy_q <= $signed(rot_rdata);
				end
				4'd4: res_qz_q <= $signed(rot_rdata);
				default: ;
			endcase
		end
	end

	// Output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status      <= res_status_q;
			out_station <= res_station_q;
			out_pos_x   <= res_px_q;
			out_pos_y   <= res_py_q;
			out_pos_z   <= res_pz_q;
			out_quat_w  <= res_qw_q;
			out_quat_x  <= res_qx_q;
			out_quat_y  <= res_qy_q;
			out_quat_z  <= res_qz_q;
			out_time    <= res_time_q;
		end
	end

endmodule

FILE: hdl/tsds_checker.sv
// Port-level checker for the tracker station deadband store, bound to the top level.
module tsds_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [tsds_pkg::STATUS_W-1:0]     status,
	input logic [tsds_pkg::STATION_W-1:0]    out_station,
	input logic [tsds_pkg::TIME_W-1:0]       out_time
);

	// Busy after each input beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous item still in work");

	// Held result beat keeps its status and time
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(out_time)))
		else $error("stalled result beat changed");

	// Only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == tsds_pkg::ST_STORED || status == tsds_pkg::ST_DISCARDED ||
		               status == tsds_pkg::ST_BAD || status == tsds_pkg::ST_FETCHED ||
		               status == tsds_pkg::ST_NONE))
		else $error("undefined status code");

	// Non-fetch results carry no record
	a_empty_record: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != tsds_pkg::ST_FETCHED) |-> (out_station == '0 && out_time == '0))
		else $error("record fields set on a non-fetch result");

endmodule

bind tracker_station_deadband_store tsds_checker u_tsds_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.out_station (out_station),
	.out_time    (out_time)
);

FILE: tb/sv/tracker_station_deadband_store_chk.sv
// Checker for the tracker station deadband store: predicts each result beat and compares it.
module tracker_station_deadband_store_chk
	import tsds_pkg::*;
#(
	parameter int STATIONS = NUM_STATIONS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     operation,
	input  logic [STATION_W-1:0]     station,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic signed [QUAT_W-1:0] quat_w,
	input  logic signed [QUAT_W-1:0] quat_x,
	input  logic signed [QUAT_W-1:0] quat_y,
	input  logic signed [QUAT_W-1:0] quat_z,
	input  logic [TIME_W-1:0]        sample_time,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [STATUS_W-1:0]      status,
	input  logic [STATION_W-1:0]     out_station,
	input  logic signed [POS_W-1:0]  out_pos_x,
	input  logic signed [POS_W-1:0]  out_pos_y,
	input  logic signed [POS_W-1:0]  out_pos_z,
	input  logic signed [QUAT_W-1:0] out_quat_w,
	input  logic signed [QUAT_W-1:0] out_quat_x,
	input  logic signed [QUAT_W-1:0] out_quat_y,
	input  logic signed [QUAT_W-1:0] out_quat_z,
	input  logic [TIME_W-1:0]        out_time,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output int                       mismatch_count,
	output int                       awaited_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [STATION_W-1:0] station;
		logic [POS_W-1:0]     px;
		logic [POS_W-1:0]     py;
		logic [POS_W-1:0]     pz;
		logic [QUAT_W-1:0]    qw;
		logic [QUAT_W-1:0]    qx;
		logic [QUAT_W-1:0]    qy;
		logic [QUAT_W-1:0]    qz;
		logic [TIME_W-1:0]    tm;
	} station_reply_t;

	// Registers as last written
	logic [MASK_W-1:0] active_mask_q;
	logic [PTH_W-1:0]  pos_thr;
	logic [QTH_W-1:0]  quat_thr;

	// Per-station record store and flags
	logic signed [POS_W-1:0]  station_pos [STATIONS][3];
	logic signed [QUAT_W-1:0] station_rot [STATIONS][4];
	logic [TIME_W-1:0]        station_time [STATIONS];
	logic [STATIONS-1:0]      seen;
	logic [STATIONS-1:0]      marked;
	int                       serve_ptr;

	station_reply_t awaited_replies [$];
	int err_total = 0;

	initial mismatch_count = 0;
	initial awaited_count = 0;

	function automatic longint unsigned sq_gap(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d < 0)
			d = -d;
		return d * d;
	endfunction

	// Apply one accepted input beat to the store and return the reply it earns
	function automatic station_reply_t apply_tracker_beat();
		station_reply_t r;
		int k;
		int n;
		longint unsigned pos_gap;
		longint unsigned rot_gap;
		logic active;
		logic passes;
		logic in_order;
		r = '0;
		if (operation == OP_SAMPLE) begin
			if (station < 1 || station > STATIONS) begin
				r.status = ST_BAD;
				return r;
			end
			k = station - 1;
			pos_gap = sq_gap(pos_x, station_pos[k][0]) + sq_gap(pos_y, station_pos[k][1]) +
				sq_gap(pos_z, station_pos[k][2]);
			rot_gap = sq_gap(quat_w, station_rot[k][0]) + sq_gap(quat_x, station_rot[k][1]) +
				sq_gap(quat_y, station_rot[k][2]) + sq_gap(quat_z, station_rot[k][3]);
			active = (k < MASK_W) && active_mask_q[k];
			passes = !seen[k] || (pos_thr == 0 && quat_thr == 0) ||
				(pos_thr <= pos_gap) || (quat_thr <= rot_gap);
			in_order = !seen[k] || (sample_time >= station_time[k]);
			if (active && passes && in_order) begin
				station_pos[k][0] = pos_x;
				station_pos[k][1] = pos_y;
				station_pos[k][2] = pos_z;
				station_rot[k][0] = quat_w;
				station_rot[k][1] = quat_x;
				station_rot[k][2] = quat_y;
				station_rot[k][3] = quat_z;
				station_time[k] = sample_time;
				seen[k] = 1'b1;
				marked[k] = 1'b1;
				r.status = ST_STORED;
			end else begin
				r.status = ST_DISCARDED;
			end
			return r;
		end
		// Scan round-robin from the pointer itself
		k = serve_ptr;
		n = 0;
		while (n < STATIONS && !marked[k]) begin
			k = (k + 1) % STATIONS;
			n++;
		end
		if (n == STATIONS) begin
			r.status = ST_NONE;
			return r;
		end
		serve_ptr = k;
		marked[k] = 1'b0;
		r.status = ST_FETCHED;
		r.station = STATION_W'(k + 1);
		r.px = station_pos[k][0];
		r.py = station_pos[k][1];
		r.pz = station_pos[k][2];
		r.qw = station_rot[k][0];
		r.qx = station_rot[k][1];
		r.qy = station_rot[k][2];
		r.qz = station_rot[k][3];
		r.tm = station_time[k];
		return r;
	endfunction

	function automatic void check_field(input string label, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", label, want, got);
			err_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		station_reply_t want;
		if (!arst_n) begin
			active_mask_q = ACTIVE_MASK_RST;
			pos_thr = '0;
			quat_thr = '0;
			seen = '0;
			marked = '0;
			serve_ptr = 0;
			foreach (station_pos[i, j])
				station_pos[i][j] = '0;
			foreach (station_rot[i, j])
				station_rot[i][j] = '0;
			foreach (station_time[i])
				station_time[i] = '0;
			awaited_replies.delete();
			awaited_count <= 0;
		end else begin
			// Compare a result beat with the oldest awaited reply
			if (out_valid && !out_stall) begin
				if (awaited_replies.size() == 0) begin
					$error("result beat with no reply awaited, status %0h", status);
					err_total++;
				end else begin
					want = awaited_replies.pop_front();
					check_field("status", want.status, status);
					check_field("out_station", want.station, out_station);
					check_field("out_pos_x", want.px, $unsigned(out_pos_x));
					check_field("out_pos_y", want.py, $unsigned(out_pos_y));
					check_field("out_pos_z", want.pz, $unsigned(out_pos_z));
					check_field("out_quat_w", want.qw, $unsigned(out_quat_w));
					check_field("out_quat_x", want.qx, $unsigned(out_quat_x));
					check_field("out_quat_y", want.qy, $unsigned(out_quat_y));
					check_field("out_quat_z", want.qz, $unsigned(out_quat_z));
					check_field("out_time", want.tm, out_time);
				end
			end
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ACTIVE_MASK: active_mask_q = cfg_data[MASK_W-1:0];
					REG_POS_THR:     pos_thr = cfg_data[PTH_W-1:0];
					REG_QUAT_THR:    quat_thr = cfg_data[QTH_W-1:0];
					default: ;
				endcase
			end
			// Predict the reply to an accepted input beat
			if (in_valid && !in_stall)
				awaited_replies.push_back(apply_tracker_beat());
			awaited_count <= awaited_replies.size();
			mismatch_count <= err_total;
		end
	end

endmodule

FILE: tb/sv/tracker_station_deadband_store_tb.sv
// Testbench top for the tracker station deadband store: clock, reset, stimulus and verdict.
module tracker_station_deadband_store_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsds_pkg::*;

	typedef struct {
		logic                     op;
		logic [STATION_W-1:0]     station;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [POS_W-1:0]  pz;
		logic signed [QUAT_W-1:0] qw;
		logic signed [QUAT_W-1:0] qx;
		logic signed [QUAT_W-1:0] qy;
		logic signed [QUAT_W-1:0] qz;
		logic [TIME_W-1:0]        tm;
	} tracker_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     operation = OP_SAMPLE;
	logic [STATION_W-1:0]     station = '0;
	logic signed [POS_W-1:0]  pos_x = '0;
	logic signed [POS_W-1:0]  pos_y = '0;
	logic signed [POS_W-1:0]  pos_z = '0;
	logic signed [QUAT_W-1:0] quat_w = '0;
	logic signed [QUAT_W-1:0] quat_x = '0;
	logic signed [QUAT_W-1:0] quat_y = '0;
	logic signed [QUAT_W-1:0] quat_z = '0;
	logic [TIME_W-1:0]        sample_time = '0;

	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic [STATION_W-1:0]     out_station;
	logic signed [POS_W-1:0]  out_pos_x;
	logic signed [POS_W-1:0]  out_pos_y;
	logic signed [POS_W-1:0]  out_pos_z;
	logic signed [QUAT_W-1:0] out_quat_w;
	logic signed [QUAT_W-1:0] out_quat_x;
	logic signed [QUAT_W-1:0] out_quat_y;
	logic signed [QUAT_W-1:0] out_quat_z;
	logic [TIME_W-1:0]        out_time;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ACTIVE_MASK;
	logic [CFG_W-1:0]     cfg_data = '0;

	int mismatch_count;
	int awaited_count;

	int send_idle_pct = 28;
	int recv_idle_pct = 65;

	// Last pose offered per station, and the latest time offered
	logic signed [POS_W-1:0]  hint_pos [NUM_STATIONS_DEF][3];
	logic signed [QUAT_W-1:0] hint_rot [NUM_STATIONS_DEF][4];
	logic [TIME_W-1:0]        hint_time [NUM_STATIONS_DEF];

	tracker_station_deadband_store #(.NUM_STATIONS(NUM_STATIONS_DEF)) dut (.*);

	tracker_station_deadband_store_chk #(.STATIONS(NUM_STATIONS_DEF)) chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Hard stop
	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic tracker_beat_t pose_beat(input int st, input int x, input int y,
		input int z, input int w, input int i, input int j, input int kk,
		input logic [TIME_W-1:0] tm);
		tracker_beat_t b;
		b.op = OP_SAMPLE;
		b.station = STATION_W'(st);
		b.px = POS_W'(x);
		b.py = POS_W'(y);
		b.pz = POS_W'(z);
		b.qw = QUAT_W'(w);
		b.qx = QUAT_W'(i);
		b.qy = QUAT_W'(j);
		b.qz = QUAT_W'(kk);
		b.tm = tm;
		return b;
	endfunction

	// Random beat: a fetch or a sample, samples mostly near the last pose with time moving forward, some noise
	function automatic tracker_beat_t next_random_beat(input bit fetch_only);
		tracker_beat_t b;
		int k;
		b.op = (fetch_only || $urandom_range(99) < 30) ? OP_FETCH : OP_SAMPLE;
		b.station = STATION_W'($urandom);
		b.px = POS_W'($urandom);
		b.py = POS_W'($urandom);
		b.pz = POS_W'($urandom);
		b.qw = QUAT_W'($urandom);
		b.qx = QUAT_W'($urandom);
		b.qy = QUAT_W'($urandom);
		b.qz = QUAT_W'($urandom);
		b.tm = $urandom;
		if (b.op == OP_FETCH)
			return b;
		if ($urandom_range(99) < 8) begin
			b.station = ($urandom_range(3) == 0) ? STATION_W'(0) :
				STATION_W'(NUM_STATIONS_DEF + $urandom_range(1, 3));
			return b;
		end
		b.station = STATION_W'($urandom_range(1, NUM_STATIONS_DEF));
		k = b.station - 1;
		if ($urandom_range(99) < 12) begin
			// broken sequence: random pose, time mostly running backwards
			if ($urandom_range(99) < 70)
				b.tm = hint_time[k] - $urandom_range(1, 1000);
			return b;
		end
		b.px = POS_W'(int'(hint_pos[k][0]) + $urandom_range(300) - 150);
		b.py = POS_W'(int'(hint_pos[k][1]) + $urandom_range(300) - 150);
		b.pz = POS_W'(int'(hint_pos[k][2]) + $urandom_range(300) - 150);
		b.qw = QUAT_W'(int'(hint_rot[k][0]) + $urandom_range(200) - 100);
		b.qx = QUAT_W'(int'(hint_rot[k][1]) + $urandom_range(200) - 100);
		b.qy = QUAT_W'(int'(hint_rot[k][2]) + $urandom_range(200) - 100);
		b.qz = QUAT_W'(int'(hint_rot[k][3]) + $urandom_range(200) - 100);
		b.tm = (hint_time[k] > 32'hFFFF_FF00) ? hint_time[k] :
			hint_time[k] + $urandom_range(40);
		if (hint_time[k] != 0 && $urandom_range(99) < 5)
			b.tm = hint_time[k] - 1;
		return b;
	endfunction

	// Offer one beat, idling first at random; valid stays high until the next call
	task automatic send_beat(input tracker_beat_t b);
		int k;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= b.op;
		station <= b.station;
		pos_x <= b.px;
		pos_y <= b.py;
		pos_z <= b.pz;
		quat_w <= b.qw;
		quat_x <= b.qx;
		quat_y <= b.qy;
		quat_z <= b.qz;
		sample_time <= b.tm;
		do @(posedge clk); while (in_stall);
		if (b.op == OP_SAMPLE && b.station >= 1 && b.station <= NUM_STATIONS_DEF) begin
			k = b.station - 1;
			hint_pos[k][0] = b.px;
			hint_pos[k][1] = b.py;
			hint_pos[k][2] = b.pz;
			hint_rot[k][0] = b.qw;
			hint_rot[k][1] = b.qx;
			hint_rot[k][2] = b.qy;
			hint_rot[k][3] = b.qz;
			if (b.tm > hint_time[k])
				hint_time[k] = b.tm;
		end
	endtask

	// Hold off input until every awaited reply has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers back to back
	task automatic write_regs(input logic [MASK_W-1:0] mask, input logic [PTH_W-1:0] pth,
		input logic [QTH_W-1:0] qth);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ACTIVE_MASK;
		cfg_data <= CFG_W'(mask);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_POS_THR;
		cfg_data <= CFG_W'(pth);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_QUAT_THR;
		cfg_data <= CFG_W'(qth);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		foreach (hint_pos[i, j])
			hint_pos[i][j] = '0;
		foreach (hint_rot[i, j])
			hint_rot[i][j] = '0;
		foreach (hint_time[i])
			hint_time[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: only station 1 active, filtering off
		send_beat(next_random_beat(1'b1));
		send_beat(pose_beat(0, 1, 2, 3, 4, 5, 6, 7, 8));
		send_beat(pose_beat(13, 1, 2, 3, 4, 5, 6, 7, 8));
		send_beat(pose_beat(15, 1, 2, 3, 4, 5, 6, 7, 8));
		send_beat(pose_beat(2, 1, 2, 3, 4, 5, 6, 7, 8));
		send_beat(pose_beat(1, 524287, -524288, 0, -32768, 32767, 0, -1, 32'd0));
		send_beat(pose_beat(1, 524287, -524288, 0, -32768, 32767, 0, -1, 32'd0));
		send_beat(next_random_beat(1'b1));
		send_beat(next_random_beat(1'b1));

		// Every station inactive
		settle();
		write_regs('0, '0, '0);
		send_beat(pose_beat(1, 7, 7, 7, 7, 7, 7, 7, 32'd9));

		// Threshold edges, backwards time, top station and maximum time
		settle();
		write_regs({MASK_W{1'b1}}, PTH_W'(100), {QTH_W{1'b1}});
		send_beat(pose_beat(12, -524288, 524287, 12345, 32767, -32768, 1, -1, 32'd5));
		send_beat(pose_beat(12, -524278, 524287, 12345, 32767, -32768, 1, -1, 32'd5));
		send_beat(pose_beat(12, -524269, 524287, 12345, 32767, -32768, 1, -1, 32'd6));
		send_beat(pose_beat(12, -524248, 524287, 12345, 32767, -32768, 1, -1, 32'd4));
		send_beat(pose_beat(7, -524288, -524288, -524288, -32768, -32768, -32768, -32768,
			32'hFFFF_FFFF));
		send_beat(pose_beat(3, 0, 0, 0, 0, 0, 0, 0, 32'd100));
		repeat (4) send_beat(next_random_beat(1'b1));

		// Quaternion threshold just missed, then just reached
		settle();
		write_regs({MASK_W{1'b1}}, {PTH_W{1'b1}}, QTH_W'(50));
		send_beat(pose_beat(3, 0, 0, 0, 7, 0, 0, 0, 32'd100));
		send_beat(pose_beat(3, 0, 0, 0, 5, 5, 0, 0, 32'd101));

		// Random segments under several register settings and idling mixes
		for (int seg = 0; seg < 6; seg++) begin
			settle();
			case (seg)
				0: write_regs({MASK_W{1'b1}}, PTH_W'(10000), QTH_W'(2500));
				1: write_regs(MASK_W'($urandom), '0, '0);
				2: write_regs({MASK_W{1'b1}}, {PTH_W{1'b1}}, {QTH_W{1'b1}});
				3: write_regs(MASK_W'($urandom), '0, QTH_W'(500));
				4: write_regs({MASK_W{1'b1}}, PTH_W'(40000), '0);
				default: write_regs(MASK_W'($urandom), PTH_W'(2500), QTH_W'(10000));
			endcase
			if (seg < 2) begin
				send_idle_pct = 28;
				recv_idle_pct = 65;
			end else if (seg < 4) begin
				send_idle_pct = 65;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(49) == 0)
					settle();
				send_beat(next_random_beat(1'b0));
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && awaited_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
